// ----- hdl/kwms_pkg.sv -----
// Package for the k-way merge block: sizes, codes and the heap entry type.
// No dependencies.
`timescale 1ns / 1ps
package kwms_pkg;
    localparam int Sources   = 8;
    localparam int Lookahead = 8;
    localparam int HeapDepth = 64;
    localparam int AW        = $clog2(HeapDepth);
    localparam int SW        = 3;
    localparam int PW        = $clog2(Lookahead + 1);

    typedef logic [1:0] t_action;
    localparam t_action ActPrime  = 2'd0;
    localparam t_action ActStart  = 2'd1;
    localparam t_action ActRefill = 2'd2;

    typedef logic [1:0] t_kind;
    localparam t_kind KindMerged  = 2'd0;
    localparam t_kind KindRequest = 2'd1;
    localparam t_kind KindDone    = 2'd2;

    typedef struct packed {
        logic [39:0] pos;
        logic [63:0] key;
        logic [SW-1:0] src;
        logic [63:0] cnt;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH_RD, S_PUSH_CMP, S_POP_RD, S_POP_LAST, S_SIFT_RD,
        S_SIFT_CMP, S_GRP_RD, S_GRP_CHK, S_OUT1, S_OUT2
    } t_state;

    function automatic logic precedes(input t_entry a, input t_entry b);
        if (a.pos != b.pos) return a.pos < b.pos;
        if (a.key != b.key) return a.key < b.key;
        return a.src < b.src;
    endfunction
endpackage

// ----- hdl/kway_merge_sum_duplicates.sv -----
// Top level of the k-way merge block: heap and pending queue in two memories; uses kwms_pkg.
// A prime is pushed with a sift-up that reads and compares the parent at each level; a refill
// answer that is pushed takes a sift-up too, and, when the group ends, a group scan pops each entry
// with a sift-down, waiting at each level on the registered heap memory read.
// One item at a time; the next is accepted once every result is transferred.
// Reset is synchronous, active low; heap contents are undefined until pushed.
`timescale 1ns / 1ps
module kway_merge_sum_duplicates (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_source,
    input  logic [63:0] i_entry_key,
    input  logic [63:0] i_entry_count,
    input  logic [39:0] i_entry_position,
    input  logic        i_exhausted,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [63:0] o_merged_key,
    output logic [63:0] o_merged_count,
    output logic [2:0]  o_request_source,
    output logic        o_last
);
    import kwms_pkg::*;

    t_entry heap [HeapDepth];
    logic [SW-1:0] pend [HeapDepth];

    t_state r_state, n_state;
    logic [AW:0]   r_fill, n_fill;
    logic [AW:0]   r_pfill, n_pfill, r_phead, n_phead;
    logic [AW-1:0] r_i, n_i;
    t_entry        r_cur, n_cur;
    logic [63:0]   r_gkey, n_gkey, r_gsum, n_gsum;
    logic          r_merging, n_merging;
    logic [PW-1:0] r_primed [Sources];
    logic [3:0]    r_cb;
    logic          r_ov, n_ov;
    t_kind         r_kind, n_kind;
    logic [63:0]   r_okey, n_okey, r_ocnt, n_ocnt;
    logic [SW-1:0] r_osrc, n_osrc;
    logic          r_olast, n_olast;
    logic          r_second, n_second;  // the push answers a refill, so a result follows it

    // heap and pending-queue memory ports
    logic          h_we;
    logic [AW-1:0] h_wa, h_ra;
    t_entry        h_wd, h_rd;
    logic          h_re2;
    logic [AW-1:0] h_ra2;
    t_entry        h_rd2;
    logic          p_we;
    logic [AW-1:0] p_wa, p_ra;
    logic [SW-1:0] p_wd, p_rd;

    always_ff @(posedge i_clk) begin
        if (h_we) heap[h_wa] <= h_wd;
        h_rd  <= heap[h_ra];
        if (h_re2) h_rd2 <= heap[h_ra2];
        if (p_we) pend[p_wa] <= p_wd;
        p_rd <= pend[p_ra];
    end

    logic in_go;
    assign o_stall = (r_state != S_IDLE) || r_ov;
    assign in_go   = i_valid && !o_stall;

    logic [63:0] lim, sat, sum_tmp;
    logic [3:0]  cb;
    always_comb begin
        cb = (r_cb == 4'd0) ? 4'd1 : r_cb;
        if (cb >= 4'd8) lim = '1;
        else lim = (64'd1 << {cb[2:0], 3'b000}) - 64'd1;
        sat = (r_gsum > lim) ? lim : r_gsum;
    end

    logic [AW:0] l_ix, r_ix;
    logic        ok_prime;
    always_comb begin
        ok_prime = !r_merging && (int'(i_source) < Sources)
                   && (r_primed[i_source] < PW'(Lookahead))
                   && (r_fill < (AW + 1)'(HeapDepth));
        l_ix = {r_i, 1'b1};
        r_ix = l_ix + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_fill = r_fill; n_pfill = r_pfill; n_phead = r_phead;
        n_i = r_i; n_cur = r_cur;
        n_gkey = r_gkey; n_gsum = r_gsum; n_merging = r_merging;
        n_ov = r_ov; n_kind = r_kind; n_okey = r_okey; n_ocnt = r_ocnt;
        n_osrc = r_osrc; n_olast = r_olast; n_second = r_second;
        sum_tmp = r_gsum + h_rd.cnt;
        if (r_ov && !i_stall) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_go) begin
                    priority case (i_action)
                        ActPrime: begin
                            if (ok_prime) begin
                                n_cur = '{pos: i_entry_position, key: i_entry_key,
                                          src: i_source, cnt: i_entry_count};
                                n_i = r_fill[AW-1:0];
                                n_fill = r_fill + 1'b1;
                                n_second = 1'b0;
                                n_state = S_PUSH_RD;
                            end
                        end
                        ActStart: begin
                            if (!r_merging) begin
                                if (r_fill == '0) begin
                                    n_ov = 1'b1; n_kind = KindDone; n_okey = '0;
                                    n_ocnt = '0; n_osrc = '0; n_olast = 1'b1;
                                end else begin
                                    n_merging = 1'b1;
                                    n_pfill = '0; n_phead = '0; n_gsum = '0;
                                    n_second = 1'b0;
                                    n_state = S_GRP_RD;
                                end
                            end
                        end
                        ActRefill: begin
                            if (r_merging && r_phead < r_pfill) begin
                                n_phead = r_phead + 1'b1;
                                n_cur = '{pos: i_entry_position, key: i_entry_key,
                                          src: p_rd, cnt: i_entry_count};
                                n_second = 1'b1;
                                if (!i_exhausted && r_fill < (AW + 1)'(HeapDepth)) begin
                                    n_i = r_fill[AW-1:0];
                                    n_fill = r_fill + 1'b1;
                                    n_state = S_PUSH_RD;
                                end else begin
                                    n_state = S_OUT1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PUSH_RD: begin
                if (r_i == '0) n_state = r_second ? S_OUT1 : S_IDLE;
                else n_state = S_PUSH_CMP;
            end
            S_PUSH_CMP: begin
                // compare with parent read last cycle; swap moves the parent down
                if (precedes(r_cur, h_rd)) begin
                    n_i = (r_i - 1'b1) >> 1;
                    n_state = S_PUSH_RD;
                end else begin
                    n_state = r_second ? S_OUT1 : S_IDLE;
                end
            end
            S_GRP_RD: n_state = S_GRP_CHK;
            S_GRP_CHK: begin
                // h_rd is the heap top
                if (r_fill != '0 && (r_pfill == '0 || h_rd.key == r_gkey)) begin
                    if (r_pfill == '0) begin
                        n_gkey = h_rd.key;
                        sum_tmp = h_rd.cnt;
                    end
                    n_gsum = (r_pfill != '0 && sum_tmp < r_gsum) ? '1 : sum_tmp;
                    n_pfill = r_pfill + 1'b1;
                    n_fill = r_fill - 1'b1;
                    n_state = S_POP_LAST;
                end else begin
                    n_ov = 1'b1; n_kind = KindRequest; n_okey = '0; n_ocnt = '0;
                    n_osrc = p_rd; n_olast = 1'b1;
                    n_state = S_OUT2;
                end
            end
            S_POP_LAST: begin
                n_i = '0;
                n_state = (r_fill == '0) ? S_GRP_RD : S_POP_RD;
            end
            S_POP_RD: begin
                n_cur = h_rd;  // former last entry
                n_state = S_SIFT_RD;
            end
            S_SIFT_RD: begin
                if (l_ix >= r_fill) n_state = S_GRP_RD;
                else n_state = S_SIFT_CMP;
            end
            S_SIFT_CMP: begin
                // h_rd left child, h_rd2 right child
                if (r_ix < r_fill && precedes(h_rd2, h_rd)) begin
                    if (precedes(h_rd2, r_cur)) begin
                        n_i = r_ix[AW-1:0]; n_state = S_SIFT_RD;
                    end else n_state = S_GRP_RD;
                end else if (precedes(h_rd, r_cur)) begin
                    n_i = l_ix[AW-1:0]; n_state = S_SIFT_RD;
                end else n_state = S_GRP_RD;
            end
            S_OUT1: begin
                if (!r_ov) begin
                    if (r_phead < r_pfill) begin
                        n_ov = 1'b1; n_kind = KindRequest; n_okey = '0; n_ocnt = '0;
                        n_osrc = p_rd; n_olast = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_ov = 1'b1; n_kind = KindMerged; n_okey = r_gkey; n_ocnt = sat;
                        n_osrc = '0; n_olast = 1'b0;
                        n_pfill = '0; n_phead = '0; n_gsum = '0;
                        if (r_fill == '0) begin
                            n_merging = 1'b0;
                            n_state = S_OUT2;
                        end else begin
                            n_state = S_GRP_RD;
                        end
                    end
                end
            end
            S_OUT2: begin
                if (!r_ov) begin
                    if (!r_merging) begin
                        n_ov = 1'b1; n_kind = KindDone; n_okey = '0; n_ocnt = '0;
                        n_osrc = '0; n_olast = 1'b1;
                    end
                    n_state = S_IDLE;
                end else if (r_merging && r_kind == KindRequest) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory control outputs
    logic group_wait;
    always_comb begin
        group_wait = (r_state == S_GRP_RD || r_state == S_GRP_CHK) && r_ov;
        h_we = 1'b0; h_wa = r_i; h_wd = r_cur; h_ra = '0;
        h_re2 = 1'b0; h_ra2 = '0;
        p_we = 1'b0; p_wa = r_pfill[AW-1:0]; p_wd = h_rd.src;
        p_ra = r_phead[AW-1:0];
        unique case (r_state)
            // read ahead the next pending source so it is ready after a refill transfer
            S_IDLE: p_ra = n_phead[AW-1:0];
            S_PUSH_RD: begin
                h_ra = (r_i - 1'b1) >> 1;
                h_we = (r_i == '0);
                h_wa = r_i;
            end
            S_PUSH_CMP: begin
                h_ra = (r_i - 1'b1) >> 1;
                h_we = 1'b1;
                h_wa = r_i;
                h_wd = precedes(r_cur, h_rd) ? h_rd : r_cur;
            end
            S_GRP_RD: h_ra = '0;
            S_GRP_CHK: begin
                h_ra = '0;
                p_ra = '0;
                p_we = r_fill != '0 && (r_pfill == '0 || h_rd.key == r_gkey);
            end
            S_POP_LAST: h_ra = r_fill[AW-1:0];
            S_POP_RD: h_ra = '0;
            S_SIFT_RD: begin
                h_ra = l_ix[AW-1:0];
                h_re2 = 1'b1;
                h_ra2 = r_ix[AW-1:0];
                h_we = (l_ix >= r_fill);
                h_wa = r_i;
            end
            S_SIFT_CMP: begin
                h_we = 1'b1; h_wa = r_i;
                if (r_ix < r_fill && precedes(h_rd2, h_rd)) begin
                    h_wd = precedes(h_rd2, r_cur) ? h_rd2 : r_cur;
                end else begin
                    h_wd = precedes(h_rd, r_cur) ? h_rd : r_cur;
                end
            end
            S_OUT1: p_ra = r_phead[AW-1:0];
            default: ;
        endcase
        if (group_wait) h_we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0; r_pfill <= '0; r_phead <= '0;
            r_gkey <= '0; r_gsum <= '0; r_merging <= 1'b0;
            r_ov <= 1'b0; r_second <= 1'b0; r_cb <= 4'd4;
            for (int s = 0; s < Sources; s++) r_primed[s] <= '0;
        end else begin
            // group scan waits until the merged entry has been transferred
            if ((r_state == S_GRP_RD || r_state == S_GRP_CHK) && r_ov) begin
                if (!i_stall) r_ov <= 1'b0;
            end else begin
                r_state <= n_state;
                r_fill <= n_fill; r_pfill <= n_pfill; r_phead <= n_phead;
                r_gkey <= n_gkey; r_gsum <= n_gsum; r_merging <= n_merging;
                r_ov <= n_ov; r_second <= n_second;
            end
            if (i_cfg_we) r_cb <= i_cfg_data;
            if (in_go && i_action == ActPrime && ok_prime)
                r_primed[i_source] <= r_primed[i_source] + 1'b1;
            if ((in_go && i_action == ActStart && !r_merging && r_fill == '0)
                || (r_state == S_OUT1 && !r_ov && r_phead >= r_pfill && r_fill == '0))
                for (int s = 0; s < Sources; s++) r_primed[s] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!group_wait) begin
            r_i <= n_i; r_cur <= n_cur;
            r_kind <= n_kind; r_okey <= n_okey; r_ocnt <= n_ocnt;
            r_osrc <= n_osrc; r_olast <= n_olast;
        end
    end

    assign o_valid          = r_ov;
    assign o_result_kind    = r_kind;
    assign o_merged_key     = r_okey;
    assign o_merged_count   = r_ocnt;
    assign o_request_source = r_osrc;
    assign o_last           = r_olast;
endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for kway_merge_sum_duplicates: primes sorted streams, runs merges,
// answers refill requests and checks every result against a heap model kept in the bench.
// Depends on kwms_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;
    import kwms_pkg::*;

    localparam int WatchLimit = 4000;
    localparam t_action ActUndef = 2'd3;

    typedef struct {
        t_kind       kind;
        logic [63:0] key;
        logic [63:0] cnt;
        logic [2:0]  src;
        logic        last;
    } t_result;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_action = ActPrime;
    logic [2:0]  i_source = '0;
    logic [63:0] i_entry_key = '0;
    logic [63:0] i_entry_count = '0;
    logic [39:0] i_entry_position = '0;
    logic        i_exhausted = 0;
    logic        i_cfg_we = 0;
    logic [3:0]  i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_result_kind;
    logic [63:0] o_merged_key;
    logic [63:0] o_merged_count;
    logic [2:0]  o_request_source;
    logic        o_last;

    kway_merge_sum_duplicates dut (.*);

    always #5 i_clk = ~i_clk;

    // model state
    logic [63:0] hp_key[HeapDepth];
    logic [63:0] hp_cnt[HeapDepth];
    logic [39:0] hp_pos[HeapDepth];
    logic [2:0]  hp_src[HeapDepth];
    int          hp_fill;
    logic [2:0]  refill_queue[HeapDepth];
    int          rq_fill, rq_head;
    logic [63:0] grp_key, grp_sum;
    bit          in_merge;
    int          primed_per_src[Sources];
    logic [3:0]  count_bytes;

    t_result     awaited[$];
    int          errors = 0;
    int          items_sent = 0;
    bit          steady = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    // per-source stream state for well-formed refills
    logic [39:0] last_pos[Sources];
    int          refills_left[Sources];
    logic [63:0] key_pool[4];

    function automatic bit ahead(int a, int b);
        if (hp_pos[a] != hp_pos[b]) return hp_pos[a] < hp_pos[b];
        if (hp_key[a] != hp_key[b]) return hp_key[a] < hp_key[b];
        return hp_src[a] < hp_src[b];
    endfunction

    task automatic swap_slots(int a, int b);
        logic [63:0] k, c;
        logic [39:0] p;
        logic [2:0]  s;
        k = hp_key[a]; hp_key[a] = hp_key[b]; hp_key[b] = k;
        c = hp_cnt[a]; hp_cnt[a] = hp_cnt[b]; hp_cnt[b] = c;
        p = hp_pos[a]; hp_pos[a] = hp_pos[b]; hp_pos[b] = p;
        s = hp_src[a]; hp_src[a] = hp_src[b]; hp_src[b] = s;
    endtask

    task automatic heap_insert(logic [63:0] k, logic [63:0] c, logic [39:0] p, logic [2:0] s);
        int i, par;
        if (hp_fill >= HeapDepth) return;
        i = hp_fill++;
        hp_key[i] = k; hp_cnt[i] = c; hp_pos[i] = p; hp_src[i] = s;
        while (i > 0) begin
            par = (i - 1) / 2;
            if (!ahead(i, par)) break;
            swap_slots(i, par);
            i = par;
        end
    endtask

    task automatic heap_remove_top();
        int i, l, r, m;
        i = 0;
        hp_fill--;
        if (hp_fill == 0) return;
        swap_slots(0, hp_fill);
        forever begin
            l = 2 * i + 1; r = l + 1; m = i;
            if (l < hp_fill && ahead(l, m)) m = l;
            if (r < hp_fill && ahead(r, m)) m = r;
            if (m == i) break;
            swap_slots(i, m);
            i = m;
        end
    endtask

    task automatic gather_group();
        logic [63:0] s;
        rq_fill = 0; rq_head = 0;
        grp_key = hp_key[0];
        grp_sum = 0;
        while (hp_fill > 0 && hp_key[0] == grp_key) begin
            s = grp_sum + hp_cnt[0];
            grp_sum = (s < grp_sum) ? '1 : s;
            if (rq_fill < HeapDepth) refill_queue[rq_fill++] = hp_src[0];
            heap_remove_top();
        end
    endtask

    function automatic logic [63:0] count_ceiling();
        int b;
        b = (count_bytes < 1) ? 1 : count_bytes;
        if (b >= 8) return '1;
        return (64'd1 << (8 * b)) - 1;
    endfunction

    task automatic end_merge();
        in_merge = 0; rq_fill = 0; rq_head = 0;
        foreach (primed_per_src[s]) primed_per_src[s] = 0;
    endtask

    task automatic await_result(t_kind kd, logic [63:0] k, logic [63:0] c, logic [2:0] s,
                                logic l);
        t_result r;
        r.kind = kd; r.key = k; r.cnt = c; r.src = s; r.last = l;
        awaited.insert(awaited.size(), r);
    endtask

    // work out the results of one accepted transfer
    task automatic predict_merge(logic [1:0] act, logic [2:0] src, logic [63:0] k,
                                 logic [63:0] c, logic [39:0] p, logic exh);
        logic [2:0]  who;
        logic [63:0] lim;
        case (act)
            ActPrime: begin
                if (!in_merge && primed_per_src[src] < Lookahead && hp_fill < HeapDepth) begin
                    heap_insert(k, c, p, src);
                    primed_per_src[src]++;
                end
            end
            ActStart: begin
                if (!in_merge) begin
                    if (hp_fill == 0) begin
                        end_merge();
                        await_result(KindDone, 0, 0, 0, 1);
                    end else begin
                        in_merge = 1;
                        gather_group();
                        await_result(KindRequest, 0, 0, refill_queue[0], 1);
                    end
                end
            end
            ActRefill: begin
                if (in_merge && rq_head < rq_fill) begin
                    who = refill_queue[rq_head++];
                    if (!exh) heap_insert(k, c, p, who);
                    if (rq_head < rq_fill) begin
                        await_result(KindRequest, 0, 0, refill_queue[rq_head], 1);
                    end else begin
                        lim = count_ceiling();
                        await_result(KindMerged, grp_key, (grp_sum > lim) ? lim : grp_sum,
                                     0, 0);
                        if (hp_fill > 0) begin
                            gather_group();
                            await_result(KindRequest, 0, 0, refill_queue[0], 1);
                        end else begin
                            end_merge();
                            await_result(KindDone, 0, 0, 0, 1);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // drive one item from a falling edge and hold it until the transfer
    task automatic send_item(logic [1:0] act, logic [2:0] src, logic [63:0] k,
                             logic [63:0] c, logic [39:0] p, logic exh);
        while (!steady && $urandom_range(99) < 10) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_action <= act; i_source <= src; i_entry_key <= k;
        i_entry_count <= c; i_entry_position <= p; i_exhausted <= exh;
        do @(posedge i_clk); while (o_stall);
        predict_merge(act, src, k, c, p, exh);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_valid <= 0;
        @(negedge i_clk);
    endtask

    // wait for every result, let the block settle, then write count_bytes
    task automatic write_count_bytes(logic [3:0] v);
        go_idle();
        while (awaited.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        count_bytes = v;
    endtask

    function automatic logic [63:0] pick_key();
        return ($urandom_range(7) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(3)];
    endfunction

    function automatic logic [63:0] pick_count();
        case ($urandom_range(5))
            0: return '1;
            1: return {$urandom, $urandom};
            2: return 64'hFFFF_FFFF_FFFF_FF00 + $urandom_range(255);
            default: return $urandom_range(300);
        endcase
    endfunction

    // one full session: prime sorted streams, start, answer refills until finished
    task automatic run_merge(int max_prime, int max_refill);
        logic [39:0] base;
        logic [2:0]  s;
        logic        exh;
        int          n;
        base = ($urandom_range(3) == 0) ? {$urandom_range(255), $urandom} - 40'd10000 : 0;
        for (int i = 0; i < 4; i++) key_pool[i] = {$urandom, $urandom} >> $urandom_range(63);
        for (int j = 0; j < Sources; j++) begin
            last_pos[j] = base;
            refills_left[j] = $urandom_range(max_refill);
        end
        n = $urandom_range(max_prime, 1);
        for (int i = 0; i < n; i++) begin
            s = $urandom_range(Sources - 1);
            last_pos[s] = last_pos[s] + $urandom_range(2);
            send_item(ActPrime, s, pick_key(), pick_count(), last_pos[s], $urandom_range(1));
        end
        send_item(ActStart, $urandom, 0, 0, 0, 0);
        while (in_merge) begin
            if ($urandom_range(19) == 0) begin
                // noise while merging: ignored actions
                case ($urandom_range(2))
                    0: send_item(ActUndef, $urandom, {$urandom, $urandom}, 0, 0, 0);
                    1: send_item(ActStart, 0, 0, 0, 0, 0);
                    default: send_item(ActPrime, $urandom, pick_key(), 1, 0, 0);
                endcase
            end else begin
                s = refill_queue[rq_head];
                exh = (refills_left[s] <= 0) || ($urandom_range(5) == 0);
                refills_left[s]--;
                last_pos[s] = last_pos[s] + $urandom_range(2);
                send_item(ActRefill, $urandom, pick_key(), pick_count(), last_pos[s], exh);
            end
        end
    endtask

    task automatic test_directed();
        send_item(ActStart, 0, 0, 0, 0, 0);                 // empty start
        send_item(ActRefill, 7, '1, '1, '1, 0);             // refill with nothing outstanding
        send_item(ActUndef, 5, '1, '1, '1, 1);              // undefined action
        for (int i = 0; i < 9; i++)                         // ninth prime of one source drops
            send_item(ActPrime, 3, 64'd5, '1, 40'd7, 0);
        send_item(ActPrime, 0, '1, '1, '1, 1);
        send_item(ActPrime, 7, 64'd0, 64'd0, 40'd0, 0);
        send_item(ActStart, 0, 0, 0, 0, 0);
        while (in_merge)
            send_item(ActRefill, 0, 0, 0, 0, 1);
    endtask

    task automatic test_byte_widths();
        logic [3:0] widths[5] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd2};
        foreach (widths[i]) begin
            write_count_bytes(widths[i]);
            run_merge(20, 2);
        end
    endtask

    // few primes so the hold-off is still running when the first result arrives
    task automatic test_backpressure();
        hold_left = 300;
        run_merge(12, 3);
    endtask

    task automatic test_random();
        int sessions;
        sessions = 0;
        while (items_sent < 1060) begin
            if (sessions % 6 == 5) write_count_bytes($urandom_range(15));
            steady = (sessions % 10 == 3);
            if ($urandom_range(9) == 0) run_merge(64, 8);
            else run_merge(24, 3);
            sessions++;
        end
        steady = 0;
    endtask

    // receiver: random stall with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= !steady && ($urandom_range(99) < 10);
        end
    end

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited.size() == 0) begin
                $error("unexpected result kind=%0d key=%h", o_result_kind, o_merged_key);
                errors++;
            end else begin
                r = awaited.pop_front();
                if (o_result_kind !== r.kind) begin
                    $error("result_kind expected %0d actual %0d", r.kind, o_result_kind);
                    errors++;
                end
                if (o_merged_key !== r.key) begin
                    $error("merged_key expected %h actual %h", r.key, o_merged_key);
                    errors++;
                end
                if (o_merged_count !== r.cnt) begin
                    $error("merged_count expected %h actual %h", r.cnt, o_merged_count);
                    errors++;
                end
                if (o_request_source !== r.src) begin
                    $error("request_source expected %0d actual %0d", r.src, o_request_source);
                    errors++;
                end
                if (o_last !== r.last) begin
                    $error("last expected %0d actual %0d", r.last, o_last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (i_rst_n && (i_valid || awaited.size() != 0)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("kway_merge_sum_duplicates regression: fail");
                $finish;
            end
        end
    end

    initial begin
        hp_fill = 0;
        count_bytes = 4;
        end_merge();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        test_directed();
        test_byte_widths();
        test_backpressure();
        test_random();
        go_idle();
        while (awaited.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0 && awaited.size() == 0) begin
            $display("kway_merge_sum_duplicates regression: pass");
        end else begin
            $display("kway_merge_sum_duplicates regression: fail");
        end
        $finish;
    end
endmodule
